// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lpd_pkg.sv =====
// ---------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ---------------------------------------------------------------------------
package lpd_pkg;

    // Number of bytes in the big-endian length header.
    localparam int HEADER_BYTES = 4;

    // Largest frame length the block ever accepts.
    localparam logic [16:0] ABS_MAX_LEN = 17'd65536;

    // Result queue depth: one waiting result plus a full header burst.
    localparam int QDEPTH = HEADER_BYTES + 1;
    localparam int LEVEL_W = $clog2(QDEPTH + 1);
    localparam int COUNT_W = $clog2(HEADER_BYTES + 1);

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } res_t;

    // Results produced by one accepted input byte.
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        res_t [HEADER_BYTES-1:0]      res;
    } push_t;

endpackage

// ===== rtl/core/lpd_out_queue.sv =====
// ---------------------------------------------------------------------------
// lpd_out_queue
// Shifting result queue that absorbs the header burst and drives the output.
// ---------------------------------------------------------------------------
module lpd_out_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpd_pkg::push_t            push,
    input  logic                      out_ready,
    output logic                      out_valid,
    output lpd_pkg::res_t             head,
    output logic [lpd_pkg::LEVEL_W-1:0] level
);
    import lpd_pkg::*;

    res_t               entry_reg  [QDEPTH];
    res_t               entry_next [QDEPTH];
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               pop;
    logic [LEVEL_W-1:0] base;

    assign out_valid = (level_reg != '0);
    assign head      = entry_reg[0];
    assign level     = level_reg;
    assign pop       = out_valid && out_ready;
    assign base      = level_reg - LEVEL_W'(pop);

    // Each entry either shifts down on a pop or takes a new result from
    // the push group when it lands just above the surviving entries.
    always_comb
    begin
        logic [LEVEL_W-1:0] offs;
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                entry_next[i] = entry_reg[i + 1];
            end
            else
            begin
                entry_next[i] = entry_reg[i];
            end
            offs = LEVEL_W'(i) - base;
            if ((LEVEL_W'(i) >= base) && (offs < LEVEL_W'(push.count)))
            begin
                entry_next[i] = push.res[offs[COUNT_W-2:0]];
            end
        end
        level_next = base + LEVEL_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

endmodule

// ===== rtl/core/length_prefix_deframer_top.sv =====
// ---------------------------------------------------------------------------
// length_prefix_deframer_top
// Splits a byte stream into frames carrying a 4-byte big-endian length.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, data_byte) takes one received byte
//   per request. The output channel (out_valid, out_ready, out_byte,
//   frame_last, bad_length) delivers frame bytes in order, header first.
//   The first three header bytes give no output. The fourth completes the
//   length: a valid length releases all four header bytes as a burst, and
//   each later byte of the frame gives one result, the final one marked by
//   frame_last. A length below four or above the maximum gives one result
//   with bad_length set, after which every input byte is swallowed.
//   An accepted byte's results are registered in the result queue. Body
//   bytes sustain one byte per cycle while the receiver keeps up. The
//   header burst loads the five-result queue, so input stalls while it
//   drains to at most one pending result.
//   cfg_write_en/cfg_write_data write max_frame_length (values above 65536
//   act as 65536); it takes effect at the next completed header.
//   Reset clears the parser to the start of a frame, empties the queue and
//   sets the maximum to 65536. When the receiver stalls, results wait in the
//   queue and input is held off once more than one result is pending.
// ---------------------------------------------------------------------------
module length_prefix_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_last,
    output logic        bad_length,
    input  logic        cfg_write_en,
    input  logic [16:0] cfg_write_data
);
    import lpd_pkg::*;

    logic [16:0]        max_len_reg;
    logic [23:0]        hdr_shift_reg;
    logic [23:0]        hdr_shift_next;
    logic [16:0]        bytes_seen_reg;
    logic [16:0]        bytes_seen_next;
    logic [16:0]        frame_size_reg;
    logic [16:0]        frame_size_next;
    logic               stopped_reg;
    logic               stopped_next;

    logic               accept;
    push_t              push;
    res_t               head;
    logic [LEVEL_W-1:0] level;

    // Length decode for the completing header byte.
    logic               len_upper;
    logic [16:0]        len_low;
    logic [16:0]        limit;
    logic               len_bad;
    logic [16:0]        bytes_inc;

    // Stopped streams are drained without producing results, so they never
    // need queue room.
    assign in_ready = stopped_reg || (level <= LEVEL_W'(1));
    assign accept   = in_valid && in_ready;

    // The 32-bit length is header_shift followed by the current byte. Any
    // bit above bit 16 makes it larger than every legal maximum.
    assign len_upper = (hdr_shift_reg[23:9] != '0);
    assign len_low   = {hdr_shift_reg[8:0], data_byte};
    assign limit     = (max_len_reg > ABS_MAX_LEN) ? ABS_MAX_LEN : max_len_reg;
    assign len_bad   = len_upper || (len_low < 17'(HEADER_BYTES)) || (len_low > limit);
    assign bytes_inc = bytes_seen_reg + 17'd1;

    always_comb
    begin
        hdr_shift_next  = hdr_shift_reg;
        bytes_seen_next = bytes_seen_reg;
        frame_size_next = frame_size_reg;
        stopped_next    = stopped_reg;
        push            = '0;

        if (accept && !stopped_reg)
        begin
            if (bytes_seen_reg < 17'(HEADER_BYTES - 1))
            begin
                // Still collecting the header.
                hdr_shift_next  = {hdr_shift_reg[15:0], data_byte};
                bytes_seen_next = bytes_inc;
            end
            else if (bytes_seen_reg == 17'(HEADER_BYTES - 1))
            begin
                hdr_shift_next = '0;
                if (len_bad)
                begin
                    stopped_next      = 1'b1;
                    push.count        = COUNT_W'(1);
                    push.res[0].data  = 8'd0;
                    push.res[0].last  = 1'b0;
                    push.res[0].bad   = 1'b1;
                end
                else
                begin
                    push.count       = COUNT_W'(HEADER_BYTES);
                    push.res[0].data = hdr_shift_reg[23:16];
                    push.res[1].data = hdr_shift_reg[15:8];
                    push.res[2].data = hdr_shift_reg[7:0];
                    push.res[3].data = data_byte;
                    if (len_low == 17'(HEADER_BYTES))
                    begin
                        // A frame made of its header alone ends here.
                        push.res[3].last = 1'b1;
                        bytes_seen_next  = '0;
                        frame_size_next  = '0;
                    end
                    else
                    begin
                        frame_size_next = len_low;
                        bytes_seen_next = 17'(HEADER_BYTES);
                    end
                end
            end
            else
            begin
                push.count       = COUNT_W'(1);
                push.res[0].data = data_byte;
                if (bytes_inc >= frame_size_reg)
                begin
                    push.res[0].last = 1'b1;
                    bytes_seen_next  = '0;
                    frame_size_next  = '0;
                end
                else
                begin
                    bytes_seen_next = bytes_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= ABS_MAX_LEN;
            hdr_shift_reg  <= '0;
            bytes_seen_reg <= '0;
            frame_size_reg <= '0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
            hdr_shift_reg  <= hdr_shift_next;
            bytes_seen_reg <= bytes_seen_next;
            frame_size_reg <= frame_size_next;
            stopped_reg    <= stopped_next;
        end
    end

    // The result queue holds the result register and absorbs header bursts.
    lpd_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .level     (level)
    );

    assign out_byte   = head.data;
    assign frame_last = head.last;
    assign bad_length = head.bad;

endmodule

// ===== rtl/core/lpd_checker.sv =====
// ---------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer output channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       frame_last,
    input logic       bad_length
);

    // A stalled result stays put.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

    // An error result never also closes a frame.
    `ASSERT_ALWAYS(a_bad_not_last, !(out_valid && bad_length && frame_last))

    // An error result carries a zero byte.
    `ASSERT_ALWAYS(a_bad_zero, !(out_valid && bad_length) || (out_byte == 8'd0))

    // Nothing follows the error result.
    `ASSERT_NEXT(a_bad_final, out_valid && out_ready && bad_length, !out_valid)

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .frame_last (frame_last),
    .bad_length (bad_length)
);

// ===== sim/length_prefix_deframer_top_tb.sv =====
// ---------------------------------------------------------------------------
// length_prefix_deframer_top_tb
// Drives a byte stream of length-prefixed frames into the deframer and checks
// every delivered byte against a cycle-free model of the parser. A short
// table of hand-written requests opens the run, random frames under several
// maximum lengths follow, and the run ends on one invalid length, after which
// the stream must stay silent.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefix_deframer_top_tb;

    import lpd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 5;
    localparam int FRAME_CAP   = 24;
    localparam int PHASE_BYTES = 8;
    localparam int SETTLE_GAP  = 4;

    // The ways a header can be refused; only one of them can be tried per run,
    // since the block stays stopped until reset.
    typedef enum int {
        ERR_SHORT,
        ERR_LONG,
        ERR_TOP_BIT,
        ERR_MAX_BELOW
    } length_fault_t;

    // One row of hand-written stimulus. When typed is set, n results are
    // expected, with data bytes taken from the top of bytes downward.
    typedef struct packed {
        logic        typed;
        logic [7:0]  data;
        logic [2:0]  n;
        logic [31:0] bytes;
        logic        last;
        logic        bad;
    } stim_row_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  data_byte      = 8'h00;
    logic        out_ready      = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [16:0] cfg_write_data = 17'd0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        frame_last;
    logic        bad_length;

    // Parser state as the block should hold it.
    logic [23:0] hdr_bytes     = 24'd0;
    logic [16:0] frame_pos     = 17'd0;
    logic [16:0] frame_len     = 17'd0;
    logic        stream_halted = 1'b0;
    logic [16:0] max_frame_len = ABS_MAX_LEN;

    res_t      expected_results [$];
    logic [7:0] held_bytes [$];
    stim_row_t directed_rows [$];

    int send_idle_pct  = 31;
    int recv_idle_pct  = 59;
    int mismatch_count = 0;
    int cycle_count    = 0;

    length_prefix_deframer_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .frame_last     (frame_last),
        .bad_length     (bad_length),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // A stored maximum above 65536 behaves as 65536.
    function automatic int eff_limit(input logic [16:0] m);
        return (m > ABS_MAX_LEN) ? int'(ABS_MAX_LEN) : int'(m);
    endfunction

    function automatic stim_row_t make_row(input int typed, input logic [7:0] d,
                                           input int n, input logic [31:0] bytes,
                                           input int last, input int bad);
        stim_row_t r;
        r.typed = 1'(typed);
        r.data  = d;
        r.n     = 3'(n);
        r.bytes = bytes;
        r.last  = 1'(last);
        r.bad   = 1'(bad);
        return r;
    endfunction

    // Expands a hand-written row into the results it promises. Only the
    // final result of the row can carry the frame end mark.
    function automatic push_t typed_push(input stim_row_t r);
        push_t p;
        int    k;
        p       = '0;
        p.count = r.n;
        for (k = 0; k < int'(r.n); k++)
        begin
            p.res[k].data = r.bytes[31 - 8 * k -: 8];
            p.res[k].last = r.last && (k == int'(r.n) - 1);
            p.res[k].bad  = r.bad;
        end
        return p;
    endfunction

    // Advances the parser by one received byte and returns the results that
    // byte releases, in delivery order starting at res[0].
    task automatic deframe_byte(input logic [7:0] b, output push_t p);
        logic [31:0] len;
        logic [31:0] lim;
        int          k;
        p = '0;
        if (stream_halted)
        begin
            // A stopped stream swallows everything.
        end
        else if (frame_pos < HEADER_BYTES - 1)
        begin
            hdr_bytes = {hdr_bytes[15:0], b};
            frame_pos = frame_pos + 1'b1;
        end
        else if (frame_pos == HEADER_BYTES - 1)
        begin
            // The length is unsigned, so a set top bit simply reads as too long.
            len = {hdr_bytes, b};
            lim = eff_limit(max_frame_len);
            if (len < HEADER_BYTES || len > lim)
            begin
                stream_halted = 1'b1;
                p.count       = COUNT_W'(1);
                p.res[0].bad  = 1'b1;
            end
            else
            begin
                p.count = COUNT_W'(HEADER_BYTES);
                for (k = 0; k < HEADER_BYTES; k++)
                    p.res[k].data = len[31 - 8 * k -: 8];
                if (len == HEADER_BYTES)
                begin
                    // A frame made of its header alone ends on the last header byte.
                    p.res[HEADER_BYTES - 1].last = 1'b1;
                    frame_pos = 17'd0;
                    frame_len = 17'd0;
                end
                else
                begin
                    frame_len = len[16:0];
                    frame_pos = 17'(HEADER_BYTES);
                end
                hdr_bytes = 24'd0;
            end
        end
        else
        begin
            frame_pos      = frame_pos + 1'b1;
            p.count        = COUNT_W'(1);
            p.res[0].data  = b;
            if (frame_pos >= frame_len)
            begin
                p.res[0].last = 1'b1;
                frame_pos     = 17'd0;
                frame_len     = 17'd0;
            end
        end
    endtask

    // Offers one byte, after a random idle stretch, and holds it until the
    // request is taken. Valid stays high on return so that back-to-back
    // requests need no second assignment in the same step.
    task automatic send_byte(input logic [7:0] b, input push_t want);
        int k;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        for (k = 0; k < int'(want.count); k++)
            expected_results.push_back(want.res[k]);
    endtask

    task automatic send_pred(input logic [7:0] b);
        push_t p;
        deframe_byte(b, p);
        send_byte(b, p);
    endtask

    // Sends the first cut bytes of a frame of len bytes with a random body;
    // the remainder is kept back for the next phase.
    task automatic send_frame(input int len, input int cut);
        logic [31:0] hdr;
        logic [7:0]  b;
        int          i;
        hdr = len;
        for (i = 0; i < len; i++)
        begin
            b = (i < HEADER_BYTES) ? hdr[8 * (HEADER_BYTES - 1 - i) +: 8]
                                   : 8'($urandom_range(0, 255));
            if (i < cut)
                send_pred(b);
            else
                held_bytes.push_back(b);
        end
    endtask

    // Random well-formed frames. The phase may end part way into one more
    // frame; a frame cut inside its header has its length checked against
    // the next phase's maximum, since the check happens only when the header
    // completes.
    task automatic run_frames(input int target, input int cap, input int next_lim);
        int sent;
        int len;
        int cut;
        int hi;
        sent = 0;
        while (sent < target)
        begin
            hi = eff_limit(max_frame_len);
            if (hi > cap)
                hi = cap;
            len = $urandom_range(HEADER_BYTES, hi);
            send_frame(len, len);
            sent += len;
        end
        if (next_lim >= HEADER_BYTES && $urandom_range(0, 2) != 0)
        begin
            cut = $urandom_range(1, 6);
            hi  = eff_limit(max_frame_len);
            if (hi > cap)
                hi = cap;
            if (cut >= HEADER_BYTES && hi <= cut)
                cut = HEADER_BYTES - 1;
            if (cut < HEADER_BYTES)
            begin
                hi = eff_limit(17'(next_lim));
                if (hi > cap)
                    hi = cap;
            end
            len = $urandom_range((cut + 1 > HEADER_BYTES) ? cut + 1 : HEADER_BYTES, hi);
            send_frame(len, cut);
        end
    endtask

    // Lowers valid and waits until every promised result is in, then waits on
    // for a header byte that produces nothing.
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_max(input logic [16:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        max_frame_len = v;
    endtask

    // Result side: checks each delivered byte against the oldest expectation
    // and stalls at random.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("out_byte: result %02h arrived with no request pending", out_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    mismatch_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0b, got %0b", want.last, frame_last);
                    mismatch_count++;
                end
                if (bad_length !== want.bad)
                begin
                    $error("bad_length: expected %0b, got %0b", want.bad, bad_length);
                    mismatch_count++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int            phase_max [PHASES];
        int            i;
        int            ph;
        push_t         p;
        stim_row_t     r;
        length_fault_t fault;
        logic [31:0]   bad_len;
        logic [7:0]    hb;

        // Maxima per random phase: the smallest legal one, a small random one,
        // the register's top value (clamped), exactly 65536, and a random one up to 255.
        phase_max[0] = HEADER_BYTES;
        phase_max[1] = $urandom_range(5, 40);
        phase_max[2] = 131071;
        phase_max[3] = 65536;
        phase_max[4] = $urandom_range(4, 255);

        // Header-only frame: silent for three bytes, then all four header
        // bytes with the end mark on the fourth.
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h04, 4, 32'h0000_0004, 1, 0));
        // Five-byte frame closed by a single all-ones body byte.
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h05, 4, 32'h0000_0005, 0, 0));
        directed_rows.push_back(make_row(1, 8'hFF, 1, 32'hFF00_0000, 1, 0));
        // Six-byte frame with a zero body byte followed by an all-ones one.
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(1, 8'h06, 4, 32'h0000_0006, 0, 0));
        directed_rows.push_back(make_row(1, 8'h00, 1, 32'h0000_0000, 0, 0));
        directed_rows.push_back(make_row(1, 8'hFF, 1, 32'hFF00_0000, 1, 0));
        // Eight-byte frame with alternating and single-bit patterns, left to the model.
        directed_rows.push_back(make_row(0, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h00, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h08, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h55, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'hAA, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h01, 0, 32'h0, 0, 0));
        directed_rows.push_back(make_row(0, 8'h80, 0, 32'h0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The table runs under the maximum left by reset.
        for (i = 0; i < directed_rows.size(); i++)
        begin
            r = directed_rows[i];
            deframe_byte(r.data, p);
            if (r.typed)
                p = typed_push(r);
            send_byte(r.data, p);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle(SETTLE_GAP);
            write_max(17'(phase_max[ph]));
            send_idle_pct = (ph < 2) ? 31 : (ph == 2) ? 59 : 0;
            recv_idle_pct = (ph < 2) ? 59 : (ph == 2) ? 31 : 0;
            while (held_bytes.size() != 0)
                send_pred(held_bytes.pop_front());
            run_frames(PHASE_BYTES, FRAME_CAP, (ph < PHASES - 1) ? phase_max[ph + 1] : 0);
        end

        // Close with one refused header; the bytes after it must be swallowed.
        settle(SETTLE_GAP);
        fault = length_fault_t'($urandom_range(0, 3));
        case (fault)
            ERR_SHORT:
                bad_len = $urandom_range(0, HEADER_BYTES - 1);
            ERR_LONG:
            begin
                write_max($urandom_range(0, 1) ? 17'd131071 : 17'($urandom_range(4, 300)));
                bad_len = eff_limit(max_frame_len) + 1 + $urandom_range(0, 2);
            end
            ERR_TOP_BIT:
                bad_len = {1'b1, 31'($urandom)};
            default:
            begin
                write_max(17'($urandom_range(0, HEADER_BYTES - 1)));
                bad_len = $urandom_range(HEADER_BYTES, 40);
            end
        endcase
        for (i = 0; i < HEADER_BYTES; i++)
        begin
            hb = bad_len[8 * (HEADER_BYTES - 1 - i) +: 8];
            deframe_byte(hb, p);
            if (i == HEADER_BYTES - 1)
                p = typed_push(make_row(1, hb, 1, 32'h0, 0, 1));
            send_byte(hb, p);
        end
        repeat (8) send_pred(8'($urandom_range(0, 255)));

        settle(2 * SETTLE_GAP);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
